// ===== sv/scsd_pkg.sv =====
// Shared constants, types and codes for the scan-context shift distance block.
`default_nettype none
package scsd_pkg;
   localparam int MAX_RINGS   = 32;
   localparam int MAX_SECTORS = 64;
   localparam int RING_W      = 5;
   localparam int SECTOR_W    = 6;
   localparam int ADDR_W      = RING_W + SECTOR_W;
   localparam int GRID_DEPTH  = MAX_RINGS * MAX_SECTORS;
   localparam int HEIGHT_W    = 16;
   localparam int DEN_W       = 17;
   localparam int FRAC_W      = 16;
   localparam int NUM_W       = DEN_W + FRAC_W;
   localparam int QUOT_W      = 17;
   localparam int STEP_W      = 5;
   localparam int NUM_LANES   = QUOT_W + 1;
   localparam int LANE_W      = 5;
   localparam int SUM_W       = 28;
   localparam int CNT_W       = 12;
   localparam int RCNT_W      = 6;
   localparam int SCNT_W      = 7;

   localparam logic [QUOT_W-1:0] SCORE_ONE = 17'h10000;

   localparam logic [RCNT_W-1:0]   RING_COUNT_RESET   = 6'd20;
   localparam logic [SCNT_W-1:0]   SECTOR_COUNT_RESET = 7'd60;
   localparam logic [HEIGHT_W-1:0] MIN_DEN_RESET      = 16'd0;

   localparam logic [1:0] CSR_RING_COUNT   = 2'd0;
   localparam logic [1:0] CSR_SECTOR_COUNT = 2'd1;
   localparam logic [1:0] CSR_MIN_DEN      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_WAIT  = 3'b100
   } state_type;

   typedef struct packed {
      logic              last;
      logic              counted;
   } lane_tag_type;

   typedef struct packed {
      logic              done;
      lane_tag_type      tag;
      logic [QUOT_W-1:0] quotient;
   } lane_out_type;
endpackage
`default_nettype wire

// ===== sv/scsd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module scsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/scsd_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit 17 bits.
`default_nettype none
module scsd_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [scsd_pkg::NUM_W-1:0]    numerator,
   input  wire logic [scsd_pkg::DEN_W-1:0]    divisor,
   output logic                               done,
   output logic [scsd_pkg::QUOT_W-1:0]        quotient
);
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [scsd_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [scsd_pkg::NUM_W-1:0]    rem_ff, rem_in;
   logic [scsd_pkg::NUM_W-1:0]    dsh_ff, dsh_in;
   logic [scsd_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic                          fits;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = scsd_pkg::STEP_W'(scsd_pkg::QUOT_W - 1);
         rem_in  = numerator;
         dsh_in  = {divisor, {scsd_pkg::FRAC_W{1'b0}}};
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[scsd_pkg::QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

// ===== sv/scsd_lane.sv =====
// One ratio lane: a divider plus the flags that travel with its cell pair.
`default_nettype none
module scsd_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [scsd_pkg::NUM_W-1:0]    numerator,
   input  wire logic [scsd_pkg::DEN_W-1:0]    divisor,
   input  wire scsd_pkg::lane_tag_type        tag,
   output scsd_pkg::lane_out_type             result
);
   scsd_pkg::lane_tag_type      tag_ff;
   logic                        div_done;
   logic [scsd_pkg::QUOT_W-1:0] div_quot;

   scsd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .numerator (numerator),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (start) begin
         tag_ff <= tag;
      end
   end

   assign result.done     = div_done;
   assign result.tag      = tag_ff;
   assign result.quotient = div_quot;
endmodule
`default_nettype wire

// ===== sv/scsd_merge.sv =====
// Merges lane results: per-shift sum and count, mean divide, best-shift tracking.
`default_nettype none
module scsd_merge (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            clear,
   input  wire scsd_pkg::lane_out_type          lane_in,
   input  wire logic [scsd_pkg::SECTOR_W-1:0]   shift_index,
   output logic                                 shift_done,
   output logic                                 found,
   output logic [scsd_pkg::SECTOR_W-1:0]        win_shift,
   output logic [scsd_pkg::QUOT_W-1:0]          best_score
);
   logic [scsd_pkg::SUM_W-1:0]    sum_ff, sum_in, sum_fin;
   logic [scsd_pkg::CNT_W-1:0]    cnt_ff, cnt_in, cnt_fin;
   logic                          found_ff, found_in;
   logic [scsd_pkg::SECTOR_W-1:0] best_sh_ff, best_sh_in;
   logic [scsd_pkg::QUOT_W-1:0]   best_ff, best_in;
   logic                          shift_done_ff, shift_done_in;
   logic                          mean_start;
   logic                          mean_done;
   logic [scsd_pkg::QUOT_W-1:0]   mean_quot;

   always_comb begin
      sum_fin = sum_ff;
      cnt_fin = cnt_ff;
      if (lane_in.tag.counted) begin
         sum_fin = sum_ff + scsd_pkg::SUM_W'(lane_in.quotient);
         cnt_fin = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      best_sh_in    = best_sh_ff;
      best_in       = best_ff;
      shift_done_in = 1'b0;
      mean_start    = 1'b0;
      if (clear) begin
         sum_in   = '0;
         cnt_in   = '0;
         found_in = 1'b0;
      end else begin
         if (lane_in.done) begin
            if (lane_in.tag.last) begin
               sum_in = '0;
               cnt_in = '0;
               // shift with no counted pair never competes
               if (cnt_fin == '0) begin
                  shift_done_in = 1'b1;
               end else begin
                  mean_start = 1'b1;
               end
            end else begin
               sum_in = sum_fin;
               cnt_in = cnt_fin;
            end
         end
         if (mean_done) begin
            shift_done_in = 1'b1;
            if (!found_ff || mean_quot < best_ff) begin
               found_in   = 1'b1;
               best_in    = mean_quot;
               best_sh_in = shift_index;
            end
         end
      end
   end

   scsd_div u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .start     (mean_start),
      .numerator (scsd_pkg::NUM_W'(sum_fin)),
      .divisor   (scsd_pkg::DEN_W'(cnt_fin)),
      .done      (mean_done),
      .quotient  (mean_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         shift_done_ff <= 1'b0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         found_ff      <= found_in;
         shift_done_ff <= shift_done_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
      end
      best_sh_ff <= best_sh_in;
      best_ff    <= best_in;
   end

   assign shift_done = shift_done_ff;
   assign found      = found_ff;
   assign win_shift  = best_sh_ff;
   assign best_score = best_ff;
endmodule
`default_nettype wire

// ===== sv/scan_context_shift_distance.sv =====
// Top level: grid load, shift-search sequencer, ratio lanes and merge stage.
//
// Usage: each req_start transaction (taken when busy is low) writes one cell pair
// (query and stored height) at ring_index/sector_index. A transaction with
// last_cell set also starts the search over all circular sector shifts; busy
// stays high until it ends. While a shift is issued, the search reads one
// cell pair per cycle from the two grid RAMs and hands it to one of 18 divider
// lanes in turn; a merge stage sums the counted Q1.16 ratios per shift and runs
// a mean divide, which a shift with no counted pair skips. The search time is
// bounded by the one-pair-per-cycle RAM read and the per-shift mean divide.
// The result is shown for one cycle with rsp_valid in the same cycle that busy
// drops; the receiver cannot stall.
// csr_ writes set ring_count, sector_count and min_denominator; csr_ready
// is high while the block is idle.
// Reset (synchronous) returns the sequencer to idle and restores register
// defaults; the grid contents are undefined until written.
`default_nettype none
module scan_context_shift_distance (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_start,
   output logic                                    busy,
   input  wire logic [scsd_pkg::RING_W-1:0]        req_ring_index,
   input  wire logic [scsd_pkg::SECTOR_W-1:0]      req_sector_index,
   input  wire logic signed [scsd_pkg::HEIGHT_W-1:0] req_query_height,
   input  wire logic signed [scsd_pkg::HEIGHT_W-1:0] req_stored_height,
   input  wire logic                               req_last_cell,
   output logic                                    rsp_valid,
   output logic [scsd_pkg::SECTOR_W-1:0]           rsp_win_shift,
   output logic [scsd_pkg::QUOT_W-1:0]             rsp_best_score,
   output logic                                    rsp_no_valid_cells,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [scsd_pkg::HEIGHT_W-1:0]      csr_data
);
   scsd_pkg::state_type           state_ff, state_in;
   logic [scsd_pkg::RCNT_W-1:0]   ring_count_ff, ring_count_in;
   logic [scsd_pkg::SCNT_W-1:0]   sector_count_ff, sector_count_in;
   logic [scsd_pkg::HEIGHT_W-1:0] min_den_ff, min_den_in;
   logic [scsd_pkg::RING_W-1:0]   rm1_ff, rm1_in, r_ff, r_in;
   logic [scsd_pkg::SECTOR_W-1:0] sm1_ff, sm1_in, s_ff, s_in, col_ff, col_in, sh_ff, sh_in;
   logic                          p1_valid_ff, p1_valid_in, p1_last_ff, p1_last_in;
   logic [scsd_pkg::LANE_W-1:0]   lane_ptr_ff, lane_ptr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [scsd_pkg::RING_W-1:0]   rings_m1;
   logic [scsd_pkg::SECTOR_W-1:0] sectors_m1;
   logic                          accept, csr_write;
   logic [scsd_pkg::ADDR_W-1:0]   wr_addr, q_rd_addr, t_rd_addr;
   logic [scsd_pkg::HEIGHT_W-1:0] q_rd, t_rd, q_mag, t_mag;
   logic [scsd_pkg::DEN_W-1:0]    den, diff_s, diff_mag;
   logic                          counted;
   logic                          merge_clear, shift_done, found;
   logic [scsd_pkg::SECTOR_W-1:0] win_shift;
   logic [scsd_pkg::QUOT_W-1:0]   best_score;
   scsd_pkg::lane_tag_type        p1_tag;
   scsd_pkg::lane_out_type        lane_res [scsd_pkg::NUM_LANES];
   scsd_pkg::lane_out_type        lane_sel;

   assign busy      = state_ff != scsd_pkg::ST_IDLE;
   assign csr_ready = !busy;
   assign accept    = req_start && !busy;
   assign csr_write = csr_valid && csr_ready;

   // Saturate the counts to 1..MAX when the search starts.
   always_comb begin
      if (ring_count_ff == '0) begin
         rings_m1 = '0;
      end else if (ring_count_ff > scsd_pkg::RCNT_W'(scsd_pkg::MAX_RINGS)) begin
         rings_m1 = scsd_pkg::RING_W'(scsd_pkg::MAX_RINGS - 1);
      end else begin
         rings_m1 = scsd_pkg::RING_W'(ring_count_ff - 1'b1);
      end
      if (sector_count_ff == '0) begin
         sectors_m1 = '0;
      end else if (sector_count_ff > scsd_pkg::SCNT_W'(scsd_pkg::MAX_SECTORS)) begin
         sectors_m1 = scsd_pkg::SECTOR_W'(scsd_pkg::MAX_SECTORS - 1);
      end else begin
         sectors_m1 = scsd_pkg::SECTOR_W'(sector_count_ff - 1'b1);
      end
   end

   always_comb begin
      ring_count_in   = ring_count_ff;
      sector_count_in = sector_count_ff;
      min_den_in      = min_den_ff;
      if (csr_write) begin
         case (csr_index)
            scsd_pkg::CSR_RING_COUNT:   ring_count_in   = csr_data[scsd_pkg::RCNT_W-1:0];
            scsd_pkg::CSR_SECTOR_COUNT: sector_count_in = csr_data[scsd_pkg::SCNT_W-1:0];
            scsd_pkg::CSR_MIN_DEN:      min_den_in      = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rm1_in       = rm1_ff;
      sm1_in       = sm1_ff;
      r_in         = r_ff;
      s_in         = s_ff;
      col_in       = col_ff;
      sh_in        = sh_ff;
      p1_valid_in  = 1'b0;
      p1_last_in   = 1'b0;
      rsp_valid_in = 1'b0;
      merge_clear  = 1'b0;
      case (state_ff)
         scsd_pkg::ST_IDLE: begin
            if (accept && req_last_cell) begin
               state_in    = scsd_pkg::ST_ISSUE;
               rm1_in      = rings_m1;
               sm1_in      = sectors_m1;
               r_in        = '0;
               s_in        = '0;
               col_in      = '0;
               sh_in       = '0;
               merge_clear = 1'b1;
            end
         end
         scsd_pkg::ST_ISSUE: begin
            p1_valid_in = 1'b1;
            p1_last_in  = (r_ff == rm1_ff) && (s_ff == sm1_ff);
            if (s_ff == sm1_ff) begin
               s_in   = '0;
               r_in   = r_ff + 1'b1;
               col_in = sh_ff;
               if (r_ff == rm1_ff) begin
                  state_in = scsd_pkg::ST_WAIT;
               end
            end else begin
               s_in   = s_ff + 1'b1;
               col_in = (col_ff == sm1_ff) ? '0 : col_ff + 1'b1;
            end
         end
         scsd_pkg::ST_WAIT: begin
            if (shift_done) begin
               if (sh_ff == sm1_ff) begin
                  state_in     = scsd_pkg::ST_IDLE;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = scsd_pkg::ST_ISSUE;
                  sh_in    = sh_ff + 1'b1;
                  col_in   = sh_ff + 1'b1;
                  r_in     = '0;
                  s_in     = '0;
               end
            end
         end
         default: state_in = scsd_pkg::ST_IDLE;
      endcase
   end

   assign lane_ptr_in = !p1_valid_ff ? lane_ptr_ff :
                        (lane_ptr_ff == scsd_pkg::LANE_W'(scsd_pkg::NUM_LANES - 1)) ? '0 :
                        lane_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= scsd_pkg::ST_IDLE;
         ring_count_ff   <= scsd_pkg::RING_COUNT_RESET;
         sector_count_ff <= scsd_pkg::SECTOR_COUNT_RESET;
         min_den_ff      <= scsd_pkg::MIN_DEN_RESET;
         p1_valid_ff     <= 1'b0;
         lane_ptr_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ring_count_ff   <= ring_count_in;
         sector_count_ff <= sector_count_in;
         min_den_ff      <= min_den_in;
         p1_valid_ff     <= p1_valid_in;
         lane_ptr_ff     <= lane_ptr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rm1_ff     <= rm1_in;
      sm1_ff     <= sm1_in;
      r_ff       <= r_in;
      s_ff       <= s_in;
      col_ff     <= col_in;
      sh_ff      <= sh_in;
      p1_last_ff <= p1_last_in;
   end

   assign wr_addr   = {req_ring_index, req_sector_index};
   assign q_rd_addr = {r_ff, s_ff};
   assign t_rd_addr = {r_ff, col_ff};

   scsd_ram #(.WIDTH(scsd_pkg::HEIGHT_W), .DEPTH(scsd_pkg::GRID_DEPTH)) u_query_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_query_height),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd)
   );

   scsd_ram #(.WIDTH(scsd_pkg::HEIGHT_W), .DEPTH(scsd_pkg::GRID_DEPTH)) u_stored_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_stored_height),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd)
   );

   // |q|, |t|, |q-t| and the threshold test for the pair just read
   always_comb begin
      q_mag    = q_rd[scsd_pkg::HEIGHT_W-1] ? (~q_rd + 1'b1) : q_rd;
      t_mag    = t_rd[scsd_pkg::HEIGHT_W-1] ? (~t_rd + 1'b1) : t_rd;
      den      = {1'b0, q_mag} + {1'b0, t_mag};
      diff_s   = {q_rd[scsd_pkg::HEIGHT_W-1], q_rd} - {t_rd[scsd_pkg::HEIGHT_W-1], t_rd};
      diff_mag = diff_s[scsd_pkg::DEN_W-1] ? (~diff_s + 1'b1) : diff_s;
      counted  = den > {1'b0, min_den_ff};
      p1_tag.last    = p1_last_ff;
      p1_tag.counted = counted;
   end

   for (genvar i = 0; i < scsd_pkg::NUM_LANES; i++) begin : g_lane
      scsd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (p1_valid_ff && (lane_ptr_ff == scsd_pkg::LANE_W'(i))),
         .numerator ({diff_mag, {scsd_pkg::FRAC_W{1'b0}}}),
         .divisor   (den),
         .tag       (p1_tag),
         .result    (lane_res[i])
      );
   end

   // lanes start on distinct cycles with equal latency: at most one finishes
   always_comb begin
      lane_sel = '0;
      for (int i = 0; i < scsd_pkg::NUM_LANES; i++) begin
         if (lane_res[i].done) begin
            lane_sel = lane_res[i];
         end
      end
   end

   scsd_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .clear       (merge_clear),
      .lane_in     (lane_sel),
      .shift_index (sh_ff),
      .shift_done  (shift_done),
      .found       (found),
      .win_shift   (win_shift),
      .best_score  (best_score)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_win_shift      = found ? win_shift : '0;
   assign rsp_best_score     = found ? best_score : scsd_pkg::SCORE_ONE;
   assign rsp_no_valid_cells = !found;
endmodule
`default_nettype wire

// ===== sv/scsd_checker.sv =====
// Port-level checker for the shift distance block, bound to the top level.
`default_nettype none
module scsd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_start,
   input wire logic                              busy,
   input wire logic                              req_last_cell,
   input wire logic                              rsp_valid,
   input wire logic [scsd_pkg::SECTOR_W-1:0]     rsp_win_shift,
   input wire logic [scsd_pkg::QUOT_W-1:0]       rsp_best_score,
   input wire logic                              rsp_no_valid_cells
);
   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && req_last_cell) |=> busy)
      else $error("search did not start after last cell");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result without preceding search");

   a_no_valid_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_valid_cells) |->
         (rsp_win_shift == '0 && rsp_best_score == scsd_pkg::SCORE_ONE))
      else $error("bad fields when no cell counted");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_score <= scsd_pkg::SCORE_ONE))
      else $error("score above one");
endmodule

bind scan_context_shift_distance scsd_checker u_scsd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_start          (req_start),
   .busy               (busy),
   .req_last_cell      (req_last_cell),
   .rsp_valid          (rsp_valid),
   .rsp_win_shift      (rsp_win_shift),
   .rsp_best_score     (rsp_best_score),
   .rsp_no_valid_cells (rsp_no_valid_cells)
);
`default_nettype wire
